### src/slpg_pkg.sv
// Package for the status LED pattern generator.
// Holds the state codes, configuration register indexes, colours and reset values.
// No dependencies; every other file of the block imports it.
package slpg_pkg;

  typedef logic [2:0]  sys_state_t;
  typedef logic [2:0]  cfg_index_t;
  typedef logic [15:0] cfg_data_t;
  typedef logic [23:0] color_t;
  typedef logic [7:0]  level_t;
  typedef logic [31:0] time_ms_t;

  // System state codes. Codes six and seven behave as the other state.
  localparam sys_state_t ST_STARTUP      = 3'd0;
  localparam sys_state_t ST_SEARCHING    = 3'd1;
  localparam sys_state_t ST_LOCK         = 3'd2;
  localparam sys_state_t ST_TRANSMITTING = 3'd3;
  localparam sys_state_t ST_ERROR        = 3'd4;
  localparam sys_state_t ST_OTHER        = 3'd5;

  // Configuration register indexes.
  localparam cfg_index_t CFG_BLINK_PERIOD  = 3'd0;
  localparam cfg_index_t CFG_FADE_INTERVAL = 3'd1;
  localparam cfg_index_t CFG_FADE_STEP     = 3'd2;
  localparam cfg_index_t CFG_LEVEL_MAX     = 3'd3;
  localparam cfg_index_t CFG_LEVEL_MIN     = 3'd4;

  localparam color_t COLOR_BLUE   = 24'h0000FF;
  localparam color_t COLOR_CYAN   = 24'h00FFFF;
  localparam color_t COLOR_GREEN  = 24'h00FF00;
  localparam color_t COLOR_YELLOW = 24'hFFFF00;
  localparam color_t COLOR_BLACK  = 24'h000000;

  localparam logic [15:0] RST_BLINK_PERIOD  = 16'd1000;
  localparam logic [15:0] RST_FADE_INTERVAL = 16'd20;
  localparam level_t      RST_FADE_STEP     = 8'd2;
  localparam level_t      RST_LEVEL_MAX     = 8'd150;
  localparam level_t      RST_LEVEL_MIN     = 8'd0;

endpackage

### src/slpg_if.sv
// Channel interfaces of the status LED pattern generator: tick input,
// result output and configuration write. Depends on slpg_pkg.

interface slpg_in_if;
  import slpg_pkg::*;
  logic       valid;
  logic       ready;
  time_ms_t   now_ms;
  sys_state_t sys_state;
  logic       state_changed;
  modport source (output valid, now_ms, sys_state, state_changed, input ready);
  modport sink   (input valid, now_ms, sys_state, state_changed, output ready);
endinterface

interface slpg_out_if;
  import slpg_pkg::*;
  logic   valid;
  logic   ready;
  logic   show_valid;
  color_t pixel_color;
  level_t pixel_level;
  modport source (output valid, show_valid, pixel_color, pixel_level, input ready);
  modport sink   (input valid, show_valid, pixel_color, pixel_level, output ready);
endinterface

interface slpg_cfg_if;
  import slpg_pkg::*;
  logic       valid;
  logic       ready;
  cfg_index_t index;
  cfg_data_t  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/status_led_pattern_generator_unit.sv
// Status LED pattern generator: one result per tick, one tick per cycle unless stalled.
// Depends on slpg_pkg and the channel interfaces in slpg_if.sv.
//
// Each tick item is turned into its result combinationally: the pattern state
// (level, direction and the two time stamps) is updated and the result register
// loaded at the edge that accepts the tick. A new tick is taken every cycle in
// which the result register is empty or its item is being taken, so the block
// sustains one item per clock; the result appears in the cycle after acceptance.
// Configuration writes are always accepted and should be made while no tick is
// in flight. Register 0 is the blink period, 1 the fade interval, 2 the fade
// step, 3 the maximum level and 4 the minimum level; other indexes are ignored.
module status_led_pattern_generator_unit (
  input  logic       clk,
  input  logic       rst_n,
  slpg_in_if.sink    in_s,
  slpg_out_if.source out_s,
  slpg_cfg_if.sink   cfg_s
);
  import slpg_pkg::*;

  logic [15:0] blink_period_r;
  logic [15:0] fade_interval_r;
  level_t      fade_step_r;
  level_t      level_max_r;
  level_t      level_min_r;

  time_ms_t    blink_stamp_r, blink_stamp_nxt;
  time_ms_t    fade_stamp_r,  fade_stamp_nxt;
  level_t      level_r,       level_nxt;
  logic        rising_r,      rising_nxt;

  logic        out_valid_r;
  logic        show_valid_r,  show_valid_nxt;
  color_t      color_r,       color_nxt;
  level_t      pix_level_r,   pix_level_nxt;

  logic        in_acc;
  time_ms_t    blink_base, fade_base;
  level_t      level_base;
  logic        rising_base;
  time_ms_t    fade_diff, blink_diff;
  logic        fade_due, blink_due;
  logic [8:0]  level_plus, min_plus;

  assign in_s.ready  = rst_n && (!out_valid_r || out_s.ready);
  assign in_acc      = in_s.valid && in_s.ready;
  assign cfg_s.ready = 1'b1;

  assign out_s.valid       = out_valid_r;
  assign out_s.show_valid  = show_valid_r;
  assign out_s.pixel_color = color_r;
  assign out_s.pixel_level = pix_level_r;

  // A state change restarts the pattern before the tick is applied.
  always_comb begin
    blink_base  = in_s.state_changed ? in_s.now_ms : blink_stamp_r;
    fade_base   = in_s.state_changed ? in_s.now_ms : fade_stamp_r;
    level_base  = in_s.state_changed ? level_min_r : level_r;
    rising_base = in_s.state_changed ? 1'b1 : rising_r;
    fade_diff   = in_s.now_ms - fade_base;
    blink_diff  = in_s.now_ms - blink_base;
    fade_due    = fade_diff >= {16'd0, fade_interval_r};
    blink_due   = blink_diff >= {16'd0, blink_period_r};
    level_plus  = {1'b0, level_base} + {1'b0, fade_step_r};
    min_plus    = {1'b0, level_min_r} + {1'b0, fade_step_r};
  end

  always_comb begin
    blink_stamp_nxt = blink_base;
    fade_stamp_nxt  = fade_base;
    level_nxt       = level_base;
    rising_nxt      = rising_base;
    show_valid_nxt  = 1'b1;
    color_nxt       = COLOR_BLACK;
    pix_level_nxt   = level_max_r;
    case (in_s.sys_state)
      ST_STARTUP: begin
        color_nxt = COLOR_BLUE;
      end
      ST_SEARCHING: begin
        if (fade_due) begin
          fade_stamp_nxt = in_s.now_ms;
          if (rising_base) begin
            // level > max - step is the same as level + step > max.
            if (level_plus > {1'b0, level_max_r}) begin
              level_nxt  = level_max_r;
              rising_nxt = 1'b0;
            end else begin
              level_nxt = level_plus[7:0];
            end
          end else begin
            if ({1'b0, level_base} < min_plus) begin
              level_nxt  = level_min_r;
              rising_nxt = 1'b1;
            end else begin
              level_nxt = level_base - fade_step_r;
            end
          end
        end
        color_nxt     = COLOR_CYAN;
        pix_level_nxt = level_nxt;
      end
      ST_LOCK: begin
        color_nxt = COLOR_GREEN;
      end
      ST_TRANSMITTING: begin
        if (blink_due) begin
          level_nxt       = (level_base <= level_min_r) ? level_max_r : level_min_r;
          blink_stamp_nxt = in_s.now_ms;
        end
        color_nxt     = COLOR_YELLOW;
        pix_level_nxt = level_nxt;
      end
      ST_ERROR: begin
        show_valid_nxt = 1'b0;
        color_nxt      = COLOR_BLACK;
        pix_level_nxt  = 8'd0;
      end
      default: begin
        color_nxt = COLOR_BLACK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_period_r  <= RST_BLINK_PERIOD;
      fade_interval_r <= RST_FADE_INTERVAL;
      fade_step_r     <= RST_FADE_STEP;
      level_max_r     <= RST_LEVEL_MAX;
      level_min_r     <= RST_LEVEL_MIN;
    end else if (cfg_s.valid) begin
      case (cfg_s.index)
        CFG_BLINK_PERIOD:  blink_period_r  <= cfg_s.data;
        CFG_FADE_INTERVAL: fade_interval_r <= cfg_s.data;
        CFG_FADE_STEP:     fade_step_r     <= cfg_s.data[7:0];
        CFG_LEVEL_MAX:     level_max_r     <= cfg_s.data[7:0];
        CFG_LEVEL_MIN:     level_min_r     <= cfg_s.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_stamp_r <= '0;
      fade_stamp_r  <= '0;
      level_r       <= '0;
      rising_r      <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      if (in_acc) begin
        blink_stamp_r <= blink_stamp_nxt;
        fade_stamp_r  <= fade_stamp_nxt;
        level_r       <= level_nxt;
        rising_r      <= rising_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_s.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      show_valid_r <= show_valid_nxt;
      color_r      <= color_nxt;
      pix_level_r  <= pix_level_nxt;
    end
  end

endmodule

### src/slpg_checker.sv
// Port-level checker for the status LED pattern generator and its bind.
// Depends on slpg_pkg and status_led_pattern_generator_unit.
module slpg_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input slpg_pkg::sys_state_t in_sys_state,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 out_show_valid,
  input slpg_pkg::color_t     out_pixel_color,
  input slpg_pkg::level_t     out_pixel_level
);
  import slpg_pkg::*;

  // A held result keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_color)
      && $stable(out_pixel_level) && $stable(out_show_valid))
    else $error("result changed while stalled");

  // Every accepted tick shows a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted tick gave no result");

  // A stalled result blocks further ticks, so none is overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("tick accepted over a stalled result");

  a_error_blank: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_sys_state == ST_ERROR |=>
      !out_show_valid && out_pixel_level == 8'd0 && out_pixel_color == COLOR_BLACK)
    else $error("error state rewrote the pixel");

  a_startup_blue: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_sys_state == ST_STARTUP |=>
      out_show_valid && out_pixel_color == COLOR_BLUE)
    else $error("startup colour wrong");

endmodule

bind status_led_pattern_generator_unit slpg_checker u_slpg_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_s.valid),
  .in_ready        (in_s.ready),
  .in_sys_state    (in_s.sys_state),
  .out_valid       (out_s.valid),
  .out_ready       (out_s.ready),
  .out_show_valid  (out_s.show_valid),
  .out_pixel_color (out_s.pixel_color),
  .out_pixel_level (out_s.pixel_level)
);
